// ----- rtl/core/pvrb_pkg.sv -----
// Package for the phase vocoder resynthesis bin block.
// Holds widths, CORDIC constants and the arctangent table. No dependencies.
package pvrb_pkg;

  localparam int unsigned HalfSizeDef = 512;
  localparam int unsigned ChanW       = 10;
  localparam int unsigned BinW        = 10;
  localparam int unsigned MagW        = 23;
  localparam int unsigned FreqW       = 24;
  localparam int unsigned FundW       = 24;
  localparam int unsigned TphW        = 32;
  localparam int unsigned PhaseW      = 32;
  localparam int unsigned OutW        = 24;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CordW       = 34;  // Q2.30 plus headroom

  localparam logic [CordW-1:0] CordicOneK = CordW'(652032874);

  typedef enum logic [0:0] {
    CfgFundamental = 1'b0,
    CfgTurnsPerHz  = 1'b1
  } cfg_idx_e;

  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] t;
    case (i)
      0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;  11: t = 32'h000517CC;
      12: t = 32'h00028BE6;  13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
      16: t = 32'h000028BE;  17: t = 32'h0000145F;
      18: t = 32'h00000A30;  19: t = 32'h00000518;
      20: t = 32'h0000028C;  21: t = 32'h00000146;
      22: t = 32'h000000A3;  23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic                    vld;
    logic [BinW-1:0]         bin;
    logic [MagW-1:0]         mag;
    logic                    nyq;
  } side_t;

endpackage

// ----- rtl/core/pvrb_cordic.sv -----
// Pipelined CORDIC rotator with magnitude scaling, rounding and saturation.
// Depends on pvrb_pkg. One angle per cycle, enable-driven stall.
module pvrb_cordic
  import pvrb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [PhaseW-1:0]        angle_i,
  input  logic [MagW-1:0]          mag_i,
  input  logic [BinW-1:0]          bin_i,
  input  logic                     nyq_i,
  output logic                     vld_o,
  output logic [BinW-1:0]          bin_o,
  output logic signed [OutW-1:0]   re_o,
  output logic signed [OutW-1:0]   im_o,
  output logic                     nyq_o
);

  localparam int unsigned NSt = CordicSteps + 1;

  logic signed [CordW-1:0] x_q [NSt];
  logic signed [CordW-1:0] y_q [NSt];
  logic signed [PhaseW:0]  z_q [NSt];
  logic                    flip_q [NSt];
  side_t                   sd_q [NSt];

  logic [PhaseW-1:0] ang_f;
  logic              flip_in;
  assign flip_in = (angle_i[PhaseW-1] ^ angle_i[PhaseW-2]);
  assign ang_f   = flip_in ? (angle_i + {1'b1, {(PhaseW-1){1'b0}}}) : angle_i;

  // Product stage, then round and saturate.
  localparam int unsigned PW = CordW + MagW + 2;
  logic signed [CordW-1:0] c_f, s_f;
  assign c_f = flip_q[NSt-1] ? -x_q[NSt-1] : x_q[NSt-1];
  assign s_f = flip_q[NSt-1] ? -y_q[NSt-1] : y_q[NSt-1];

  logic signed [PW-1:0] pc_q, ps_q;
  side_t                pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSt; k++) sd_q[k].vld <= 1'b0;
      pd_q.vld <= 1'b0;
    end else if (en_i) begin
      sd_q[0].vld <= vld_i;
      for (int k = 1; k < NSt; k++) sd_q[k].vld <= sd_q[k-1].vld;
      x_q[0]      <= CordicOneK;
      y_q[0]      <= '0;
      z_q[0]      <= {ang_f[PhaseW-1], ang_f};
      flip_q[0]   <= flip_in;
      sd_q[0].bin <= bin_i;
      sd_q[0].mag <= mag_i;
      sd_q[0].nyq <= nyq_i;
      for (int k = 0; k < CordicSteps; k++) begin
        if (!z_q[k][PhaseW]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - $signed({1'b0, atan_turns(k)});
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + $signed({1'b0, atan_turns(k)});
        end
        flip_q[k+1]   <= flip_q[k];
        sd_q[k+1].bin <= sd_q[k].bin;
        sd_q[k+1].mag <= sd_q[k].mag;
        sd_q[k+1].nyq <= sd_q[k].nyq;
      end
      pd_q.vld <= sd_q[NSt-1].vld;
      pc_q     <= PW'($signed({1'b0, sd_q[NSt-1].mag})) * PW'(c_f);
      ps_q     <= -(PW'($signed({1'b0, sd_q[NSt-1].mag})) * PW'(s_f));
      pd_q.bin <= sd_q[NSt-1].bin;
      pd_q.mag <= sd_q[NSt-1].mag;
      pd_q.nyq <= sd_q[NSt-1].nyq;
    end
  end

  function automatic logic signed [OutW-1:0] rnd_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + PW'(64'sd1 <<< 29)) >>> 30;
    if (r > PW'(64'sd8388607))       return OutW'(24'sh7FFFFF);
    else if (r < -PW'(64'sd8388608)) return OutW'(24'sh800000);
    else                             return r[OutW-1:0];
  endfunction

  assign vld_o = pd_q.vld;
  assign bin_o = pd_q.bin;
  assign nyq_o = pd_q.nyq;
  assign re_o  = rnd_sat(pc_q);
  assign im_o  = pd_q.nyq ? '0 : rnd_sat(ps_q);

endmodule

// ----- rtl/core/phase_vocoder_resynth_bin.sv -----
// Top level: phase accumulation per channel in a RAM with registered read,
// then CORDIC polar-to-rectangular. Depends on pvrb_pkg, pvrb_cordic.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | channel, source_bin, magnitude, frequency, first_frame
//  out     | out | out_valid_o/out_stall_i | target_bin, real_value, imag_value, is_nyquist
//  cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while not stalled; 3 increment/RAM stages,
// 25 CORDIC stages for the 24-step CORDIC pipe, then 1 product stage.
// The whole pipe holds when the output is stalled; in_stall_o = out_stall_i | clr_q.
// After reset a clearing pass zeroes all HALF_SIZE+1 phase RAM entries;
// no input is taken during it. Back-to-back hits on one channel are forwarded.
module phase_vocoder_resynth_bin
  import pvrb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [TphW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ChanW-1:0]        channel_i,
  input  logic [BinW-1:0]         source_bin_i,
  input  logic [MagW-1:0]         magnitude_i,
  input  logic signed [FreqW-1:0] frequency_i,
  input  logic                    first_frame_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [BinW-1:0]         target_bin_o,
  output logic signed [OutW-1:0]  real_value_o,
  output logic signed [OutW-1:0]  imag_value_o,
  output logic                    is_nyquist_o
);

  localparam int unsigned HALF_SIZE = HalfSizeDef;
  localparam int unsigned Depth = HALF_SIZE + 1;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DW    = FreqW + BinW + 2;   // delta width
  localparam int unsigned MW    = DW + TphW;

  logic [FundW-1:0] fund_q;
  logic [TphW-1:0]  tph_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fund_q <= '0;
      tph_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFundamental: fund_q <= cfg_data_i[FundW-1:0];
        CfgTurnsPerHz:  tph_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(Depth - 1)) clr_q <= 1'b0;
    end
  end

  logic en;
  assign en         = !out_stall_i;
  assign in_stall_o = out_stall_i | clr_q;
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // stage 1: delta, RAM read issued
  logic              v1_q, rng1_q, first1_q;
  logic [AW-1:0]     a1_q;
  logic signed [DW-1:0] d1_q;
  side_t             s1_q;
  // stage 2: increment product
  logic              v2_q, rng2_q, first2_q, fw2_q;
  logic [AW-1:0]     a2_q;
  logic [PhaseW-1:0] inc2_q, ram_rd_q, fwv2_q;
  side_t             s2_q;
  // stage 3: accumulated phase
  logic              v3_q;
  logic [PhaseW-1:0] ph3_q;
  side_t             s3_q;
  logic              wr3_q;
  logic [AW-1:0]     a3_q;

  logic [PhaseW-1:0] mem [Depth];

  logic in_rng;
  assign in_rng = channel_i <= ChanW'(HALF_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; wr3_q <= 1'b0;
    end else if (en) begin
      v1_q  <= acc;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      wr3_q <= v2_q && rng2_q;
    end
  end

  logic [PhaseW-1:0] old2, ph2;
  // forwarded value replaces a read that missed a write still in flight
  always_comb begin
    old2 = fw2_q ? fwv2_q : ram_rd_q;
    if (!rng2_q || first2_q) old2 = '0;
    ph2 = old2 + inc2_q;
  end

  logic fw1, fw_s2;
  assign fw1   = wr3_q && v3_q && (a3_q == a1_q);
  assign fw_s2 = v2_q && rng2_q && (a2_q == a1_q);

  logic signed [MW-1:0] prod1;
  assign prod1 = MW'(d1_q) * $signed({1'b0, tph_q});

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (en && wr3_q && v3_q) begin
      mem[a3_q] <= ph3_q;
    end
    if (en) begin
      ram_rd_q <= mem[a1_q];
      // stage 1
      a1_q     <= channel_i[AW-1:0];
      rng1_q   <= in_rng;
      first1_q <= first_frame_i;
      d1_q     <= DW'(frequency_i) - $signed(DW'(source_bin_i) * DW'(fund_q));
      s1_q.vld <= acc;
      s1_q.bin <= source_bin_i;
      s1_q.mag <= magnitude_i;
      s1_q.nyq <= source_bin_i == BinW'(HALF_SIZE);
      // stage 2; the newer of the two pending writes wins
      a2_q     <= a1_q;
      rng2_q   <= rng1_q;
      first2_q <= first1_q;
      fw2_q    <= fw1 || fw_s2;
      fwv2_q   <= fw_s2 ? ph2 : ph3_q;
      inc2_q   <= prod1[PhaseW+7:8];
      s2_q     <= s1_q;
      // stage 3
      ph3_q    <= ph2;
      a3_q     <= a2_q;
      s3_q     <= s2_q;
    end
  end

  pvrb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v3_q),
    .angle_i (ph3_q),
    .mag_i   (s3_q.mag),
    .bin_i   (s3_q.bin),
    .nyq_i   (s3_q.nyq),
    .vld_o   (out_valid_o),
    .bin_o   (target_bin_o),
    .re_o    (real_value_o),
    .im_o    (imag_value_o),
    .nyq_o   (is_nyquist_o)
  );

endmodule

// ----- dv/tb.sv -----
// Testbench for phase_vocoder_resynth_bin: directed table then random bins,
// each result checked against an in-bench phase/CORDIC predictor.
// Depends on pvrb_pkg and the phase_vocoder_resynth_bin RTL.
`timescale 1ns / 100ps

module tb;
  import pvrb_pkg::*;

  localparam int unsigned HalfSize = 512;
  localparam int unsigned Latency  = 30;
  localparam logic [31:0] AtanTab [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [BinW-1:0]  bin;
    logic [MagW-1:0]  mag;
    logic [FreqW-1:0] freq;
    logic             first;
  } bin_in_t;

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic [OutW-1:0] re;
    logic [OutW-1:0] im;
    logic            nyq;
  } rect_t;

  typedef struct {
    bin_in_t    stim;
    logic       has_exp;
    logic [OutW-1:0] re;
    logic [OutW-1:0] im;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [TphW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ChanW-1:0] channel_i = '0;
  logic [BinW-1:0] source_bin_i = '0;
  logic [MagW-1:0] magnitude_i = '0;
  logic signed [FreqW-1:0] frequency_i = '0;
  logic first_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [BinW-1:0] target_bin_o;
  logic signed [OutW-1:0] real_value_o;
  logic signed [OutW-1:0] imag_value_o;
  logic is_nyquist_o;

  always #10 clk_i = ~clk_i;

  phase_vocoder_resynth_bin i_dut (.*);

  logic [31:0] phase_acc [HalfSize+1];
  logic [23:0] fund_hz;
  logic [31:0] tph;
  rect_t rect_q [$];
  int errors = 0;
  bit quiet = 0;
  bit hold_off = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat23(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Advances the channel phase and returns the rotated rectangular pair.
  function automatic rect_t resynth(bin_in_t b);
    rect_t r;
    longint dlt, x, y, z, dx, dy, re, im, mg;
    logic [63:0] prod;
    logic [31:0] ph, ang;
    bit in_rng, flip;
    in_rng = b.chan <= HalfSize;
    dlt = longint'($signed(b.freq)) - longint'(b.bin) * longint'(fund_hz);
    prod = 64'(dlt) * 64'(tph);
    ph = (in_rng && !b.first) ? phase_acc[b.chan] : 32'd0;
    ph = ph + prod[39:8];
    if (in_rng) phase_acc[b.chan] = ph;
    ang = ph;
    flip = ang[31:30] == 2'd1 || ang[31:30] == 2'd2;
    if (flip) ang = ang + 32'h80000000;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(AtanTab[i]);
      end else begin
        x += dx; y -= dy; z += longint'(AtanTab[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    mg = longint'(b.mag);
    re = sat23(fshr(mg * x + (64'sd1 << 29), 30));
    im = sat23(fshr(-(mg * y) + (64'sd1 << 29), 30));
    r.nyq = b.bin == HalfSize;
    if (r.nyq) im = 0;
    r.bin = b.bin;
    r.re = re[23:0];
    r.im = im[23:0];
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgFundamental) fund_hz = val[23:0];
    else tph = val;
  endtask

  // Offers one transaction from the falling edge and waits for acceptance.
  task automatic send_bin(bin_in_t b, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    in_valid_i = 1'b1;
    channel_i = b.chan;
    source_bin_i = b.bin;
    magnitude_i = b.mag;
    frequency_i = b.freq;
    first_frame_i = b.first;
    do @(posedge clk_i); while (in_stall_o);
    rect_q.push_back(resynth(b));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain;
    int n = 0;
    while (rect_q.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  function automatic bin_in_t rand_bin();
    bin_in_t b;
    b.chan = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 24));
    b.bin = ($urandom_range(0, 7) == 0) ? 10'($urandom) :
            ($urandom_range(0, 7) == 0) ? 10'(HalfSize) : 10'($urandom_range(0, HalfSize));
    b.mag = 23'($urandom);
    b.freq = 24'($urandom);
    b.first = $urandom_range(0, 9) == 0;
    return b;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) out_stall_i <= 1'b1;
    else if (!quiet && $urandom_range(0, 5) == 0) out_stall_i <= 1'b1;
    else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    rect_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rect_q.size() == 0) begin
        $display("%0t unexpected result bin %0d", $time, target_bin_o);
        errors++;
      end else begin
        e = rect_q.pop_front();
        if (e != {target_bin_o, real_value_o, imag_value_o, is_nyquist_o}) begin
          $display("%0t mismatch exp bin %0d re %0d im %0d nyq %0b", $time, e.bin,
                   $signed(e.re), $signed(e.im), e.nyq);
          $display("%0t          got bin %0d re %0d im %0d nyq %0b", $time, target_bin_o,
                   real_value_o, imag_value_o, is_nyquist_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("[phase_vocoder_resynth_bin] ERROR");
    $finish;
  end

  initial begin
    row_t dir [$];
    rect_t got;
    bin_in_t b;
    for (int i = 0; i <= HalfSize; i++) phase_acc[i] = '0;
    fund_hz = '0;
    tph = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // After reset both registers are zero: phase stays zero, so re = mag, im = 0
    dir.push_back('{'{10'd0, 10'd0, 23'h100000, 24'h7FFFFF, 1'b0}, 1'b1, 24'h100000, 24'd0});
    dir.push_back('{'{10'd512, 10'd512, 23'd0, 24'h800000, 1'b1}, 1'b1, 24'd0, 24'd0});
    dir.push_back('{'{10'h3FF, 10'h3FF, 23'd1, 24'd0, 1'b0}, 1'b1, 24'd1, 24'd0});
    foreach (dir[i]) begin
      b = dir[i].stim;
      send_bin(b, 1'b1);
      got = rect_q[$];
      if (dir[i].has_exp && (got.re != dir[i].re || got.im != dir[i].im)) begin
        $display("%0t table row %0d exp re %0d im %0d, predictor re %0d im %0d", $time, i,
                 $signed(dir[i].re), $signed(dir[i].im), $signed(got.re), $signed(got.im));
        errors++;
      end
    end
    drain();
    write_reg(CfgFundamental, 32'hFFFFFF);
    write_reg(CfgTurnsPerHz, 32'hFFFFFFFF);
    dir.delete();
    // Extremes of every field, Nyquist, out-of-range channel, first-frame reset
    dir.push_back('{'{10'd0, 10'd512, 23'h7FFFFF, 24'h7FFFFF, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd0, 10'd1, 23'h7FFFFF, 24'h800000, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd0, 10'd1, 23'h7FFFFF, 24'h800000, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd0, 10'd3, 23'h400000, 24'h000100, 1'b1}, 1'b0, '0, '0});
    dir.push_back('{'{10'd513, 10'd1023, 23'h2AAAAA, 24'h555555, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd1023, 10'd700, 23'h555555, 24'hAAAAAA, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd512, 10'd0, 23'h7FFFFF, 24'h000001, 1'b0}, 1'b0, '0, '0});
    dir.push_back('{'{10'd512, 10'd512, 23'h7FFFFF, 24'hFFFFFF, 1'b0}, 1'b0, '0, '0});
    foreach (dir[i]) send_bin(dir[i].stim, 1'b0);
    drain();
    write_reg(CfgFundamental, 32'h000A00);
    write_reg(CfgTurnsPerHz, 32'h00010000);
    // Long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (80) @(negedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 60; i++) send_bin(rand_bin(), 1'b0);
    join
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CfgFundamental, 32'($urandom));
      write_reg(CfgTurnsPerHz, (ph == 3) ? 32'd0 : $urandom);
      if (ph == 3) quiet = 1;
      for (int i = 0; i < 160; i++) send_bin(rand_bin(), 1'b1);
    end
    drain();
    if (errors == 0 && rect_q.size() == 0) begin
      $display("[phase_vocoder_resynth_bin] OK");
    end else begin
      $display("[phase_vocoder_resynth_bin] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pvrb_pkg.sv
rtl/core/pvrb_cordic.sv
rtl/core/phase_vocoder_resynth_bin.sv
dv/tb.sv
